FILE: rtl/core/mmp_pkg.sv
package mmp_pkg;

    localparam int NLIMBS = 9;
    localparam int LIMB_W = 59;
    localparam int IDX_W  = 4;
    localparam int HALF_W = 30;
    localparam int PROD_W = 2 * LIMB_W;
    localparam int COL_W  = PROD_W + 6;
    localparam int Q_DEPTH = 2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NLIMBS - 1);

    typedef logic [NLIMBS-1:0][LIMB_W-1:0] limb_vec_t;

    typedef struct packed {
        limb_vec_t f;
        limb_vec_t g;
    } job_t;

endpackage

FILE: rtl/core/mmp_if.sv
interface mmp_in_if;
    import mmp_pkg::*;
    logic              valid;
    logic              ready;
    logic [LIMB_W-1:0] f_limb;
    logic [LIMB_W-1:0] g_limb;

    modport source (output valid, output f_limb, output g_limb, input ready);
    modport sink   (input valid, input f_limb, input g_limb, output ready);
endinterface

interface mmp_out_if;
    import mmp_pkg::*;
    logic              valid;
    logic              ready;
    logic [LIMB_W-1:0] z_limb;
    logic [IDX_W-1:0]  limb_index;
    logic              last_limb;

    modport source (output valid, output z_limb, output limb_index, output last_limb,
                    input ready);
    modport sink   (input valid, input z_limb, input limb_index, input last_limb,
                    output ready);
endinterface

FILE: rtl/core/mmp_front.sv
module mmp_front
    import mmp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    mmp_in_if.sink limbs,
    output logic  q_push,
    output job_t  q_data,
    input  logic  q_ready
);

    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] cnt_next;
    limb_vec_t        f_reg;
    limb_vec_t        g_reg;
    logic             take;

    always_comb
    begin
        limbs.ready = (cnt_reg != LAST_IDX) || q_ready;
        take        = limbs.valid && limbs.ready;
        q_push      = take && (cnt_reg == LAST_IDX);
        q_data.f    = f_reg;
        q_data.g    = g_reg;
        q_data.f[NLIMBS-1] = limbs.f_limb;
        q_data.g[NLIMBS-1] = limbs.g_limb;
        cnt_next    = cnt_reg;
        if (take)
        begin
            cnt_next = (cnt_reg == LAST_IDX) ? '0 : cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            f_reg[cnt_reg] <= limbs.f_limb;
            g_reg[cnt_reg] <= limbs.g_limb;
        end
    end

endmodule

FILE: rtl/core/mmp_queue.sv
module mmp_queue
    import mmp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    output logic push_ready,
    input  logic pop,
    output job_t pop_data,
    output logic pop_valid
);

    job_t       mem [Q_DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_push;
    logic       do_pop;

    always_comb
    begin
        push_ready = (cnt_reg != 2'(Q_DEPTH));
        pop_valid  = (cnt_reg != 2'd0);
        do_push    = push && push_ready;
        do_pop     = pop && pop_valid;
        pop_data   = mem[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/core/mmp_back.sv
module mmp_back
    import mmp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   q_valid,
    input  job_t   q_data,
    output logic   q_pop,
    mmp_out_if.source result
);

    typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_DRAIN, ST_CARRY, ST_OUT} state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] i_reg;
    logic [IDX_W-1:0] j_reg;
    logic [IDX_W-1:0] c_reg;
    logic [IDX_W-1:0] o_reg;
    logic             s1_vld_reg;
    logic             s2_vld_reg;

    job_t             job_reg;
    logic [59:0]      p00_reg;
    logic [58:0]      p01_reg;
    logic [58:0]      p10_reg;
    logic [57:0]      p11_reg;
    logic [IDX_W-1:0] k1_reg;
    logic             w1_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [IDX_W-1:0] k2_reg;
    logic             w2_reg;
    logic [COL_W-1:0] col_reg [NLIMBS];
    logic [COL_W-1:0] acc_reg;
    logic [56:0]      low8_reg;
    logic [LIMB_W-1:0] z_reg [NLIMBS];

    logic [LIMB_W-1:0] a_op;
    logic [LIMB_W-1:0] b_op;
    logic [IDX_W:0]    ksum;
    logic              kwrap;
    logic [IDX_W-1:0]  kidx;
    logic [59:0]       mid;
    logic [IDX_W-1:0]  cidx;
    logic [COL_W-1:0]  csum;
    logic [COL_W-1:0]  top;

    always_comb
    begin
        q_pop = (state_reg == ST_IDLE) && q_valid;
        a_op  = job_reg.f[i_reg];
        b_op  = job_reg.g[j_reg];
        ksum  = {1'b0, i_reg} + {1'b0, j_reg};
        kwrap = (ksum >= (IDX_W+1)'(NLIMBS));
        kidx  = kwrap ? IDX_W'(ksum - (IDX_W+1)'(NLIMBS)) : IDX_W'(ksum);
        mid   = {1'b0, p01_reg} + {1'b0, p10_reg};
        cidx  = c_reg - 1'b1;
        csum  = col_reg[cidx] + acc_reg;
        top   = acc_reg + COL_W'(low8_reg);
        result.valid      = (state_reg == ST_OUT);
        result.z_limb     = z_reg[o_reg];
        result.limb_index = o_reg;
        result.last_limb  = (o_reg == LAST_IDX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            i_reg      <= '0;
            j_reg      <= '0;
            c_reg      <= '0;
            o_reg      <= '0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= (state_reg == ST_MUL);
            s2_vld_reg <= s1_vld_reg;
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        i_reg     <= '0;
                        j_reg     <= '0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    if (j_reg == LAST_IDX)
                    begin
                        j_reg <= '0;
                        if (i_reg == LAST_IDX)
                        begin
                            state_reg <= ST_DRAIN;
                        end
                        else
                        begin
                            i_reg <= i_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    if (!s1_vld_reg && !s2_vld_reg)
                    begin
                        c_reg     <= '0;
                        state_reg <= ST_CARRY;
                    end
                end
                ST_CARRY:
                begin
                    if (c_reg == IDX_W'(NLIMBS))
                    begin
                        o_reg     <= '0;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        c_reg <= c_reg + 1'b1;
                    end
                end
                ST_OUT:
                begin
                    if (result.ready)
                    begin
                        if (o_reg == LAST_IDX)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            o_reg <= o_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_data;
            for (int n = 0; n < NLIMBS; n++)
            begin
                col_reg[n] <= '0;
            end
        end
        // four half-width partial products of one limb product
        p00_reg <= a_op[HALF_W-1:0] * b_op[HALF_W-1:0];
        p01_reg <= a_op[HALF_W-1:0] * b_op[LIMB_W-1:HALF_W];
        p10_reg <= a_op[LIMB_W-1:HALF_W] * b_op[HALF_W-1:0];
        p11_reg <= a_op[LIMB_W-1:HALF_W] * b_op[LIMB_W-1:HALF_W];
        k1_reg  <= kidx;
        w1_reg  <= kwrap;
        prod_reg <= {p11_reg, 60'd0} + (PROD_W'(mid) << HALF_W) + PROD_W'(p00_reg);
        k2_reg  <= k1_reg;
        w2_reg  <= w1_reg;
        // wrapped columns count twice since 2^522 = 2 mod p
        if (s2_vld_reg)
        begin
            col_reg[k2_reg] <= col_reg[k2_reg] +
                (w2_reg ? {5'd0, prod_reg, 1'b0} : {6'd0, prod_reg});
        end
        if (state_reg == ST_CARRY)
        begin
            if (c_reg == '0)
            begin
                low8_reg <= col_reg[NLIMBS-1][56:0];
                acc_reg  <= col_reg[NLIMBS-1] >> 57;
            end
            else if (c_reg == IDX_W'(NLIMBS))
            begin
                z_reg[NLIMBS-1] <= {2'b0, top[56:0]};
                z_reg[0]        <= z_reg[0] + LIMB_W'(top >> 57);
            end
            else
            begin
                z_reg[cidx] <= {1'b0, csum[57:0]};
                acc_reg     <= csum >> 58;
            end
        end
    end

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.last_limb == (result.limb_index == LAST_IDX)))
        else $error("last flag off its limb");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.ready && result.last_limb) |=> (state_reg == ST_IDLE))
        else $error("result run did not end");

    a_no_late_acc: assert property (@(posedge clk) disable iff (!rst_n)
        s2_vld_reg |-> (state_reg == ST_MUL || state_reg == ST_DRAIN))
        else $error("column update outside multiply phase");

    a_out_idx: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.limb_index <= LAST_IDX))
        else $error("limb index out of range");

endmodule

FILE: rtl/core/modmul_p521_tmvp_core.sv
// multiplier modulo 2^521-1: nine requests load limb i of both operands (limb 0 first),
// then nine result requests return the partly reduced product, limb 0 first, last_limb on
// limb 8. a two-entry queue of loaded operand sets lets the next nine limbs load while the
// product is formed. the product is built from 81 limb products issued one per cycle
// through a shared 59x59 multiplier built of four half-width (30- and 29-bit) multipliers,
// then partial-product, product-sum and column-accumulate pipeline registers, ten carry
// steps and nine result limbs, so back to back the pace is set by the single shared multiplier.
module modmul_p521_tmvp_core
    import mmp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    mmp_in_if.sink    limbs,
    mmp_out_if.source result
);

    logic q_push;
    logic q_ready;
    job_t q_wdata;
    logic q_pop;
    logic q_valid;
    job_t q_rdata;

    mmp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .limbs   (limbs),
        .q_push  (q_push),
        .q_data  (q_wdata),
        .q_ready (q_ready)
    );

    mmp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_wdata),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_data   (q_rdata),
        .pop_valid  (q_valid)
    );

    mmp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule
